// ===== design/hsfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants for the sensor reply decoder
// CRC-8 step, byte positions, status codes and conversion constants.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // CRC-8, poly x^8+x^5+x^4+1, init all ones, no reflection, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte positions within a six-byte reply
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_BAD = 2'd1;
    localparam logic [1:0] ST_HUM_BAD  = 2'd2;

    // conversion constants: full scale of the raw words is 2^16 - 1
    localparam int TEMP_SCALE  = 175;
    localparam int TEMP_OFFSET = 45;
    localparam int HUM_SCALE   = 100;
    localparam int RAW_FULL    = 65535;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // one finished reply handed from front to back
    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic [1:0]  status;
    } job_t;

    // one byte of CRC-8, eight shift steps unrolled
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/hsfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_front: byte intake for the sensor reply decoder
// Tracks byte position, runs the CRC, stores raw words and queues one job
// with its CRC status when the sixth byte of a reply arrives.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output logic               push,
    output hsfd_pkg::job_t     push_data,
    input  wire logic          q_full
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        tbad_reg, tbad_next;

    logic [2:0]  eff_pos;
    logic [7:0]  crc_base;
    logic [7:0]  crc_new;
    logic        is_last;
    logic        take;
    logic        hum_bad;

    // position after a frame start or an out-of-range value restarts at 0
    assign eff_pos  = (frame_start || pos_reg > hsfd_pkg::POS_H_CRC) ? hsfd_pkg::POS_T_MSB
                                                                      : pos_reg;
    assign is_last  = (eff_pos == hsfd_pkg::POS_H_CRC);
    assign in_ready = !is_last || !q_full;
    assign take     = in_valid && in_ready;

    // CRC restarts on the first byte of each word
    assign crc_base = (eff_pos == hsfd_pkg::POS_T_MSB || eff_pos == hsfd_pkg::POS_H_MSB)
                      ? hsfd_pkg::CRC_INIT : crc_reg;
    assign crc_new  = hsfd_pkg::crc8_update(crc_base, rx_byte);
    assign hum_bad  = (crc_reg != rx_byte);

    // next-state per byte position
    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        raw_t_next = raw_t_reg;
        raw_h_next = raw_h_reg;
        tbad_next  = tbad_reg;
        if (take)
        begin
            case (eff_pos)
                hsfd_pkg::POS_T_MSB:
                begin
                    crc_next   = crc_new;
                    raw_t_next = {rx_byte, raw_t_reg[7:0]};
                    pos_next   = hsfd_pkg::POS_T_LSB;
                end
                hsfd_pkg::POS_T_LSB:
                begin
                    crc_next   = crc_new;
                    raw_t_next = {raw_t_reg[15:8], rx_byte};
                    pos_next   = hsfd_pkg::POS_T_CRC;
                end
                hsfd_pkg::POS_T_CRC:
                begin
                    tbad_next = (crc_reg != rx_byte);
                    crc_next  = hsfd_pkg::CRC_INIT;
                    pos_next  = hsfd_pkg::POS_H_MSB;
                end
                hsfd_pkg::POS_H_MSB:
                begin
                    crc_next   = crc_new;
                    raw_h_next = {rx_byte, raw_h_reg[7:0]};
                    pos_next   = hsfd_pkg::POS_H_LSB;
                end
                hsfd_pkg::POS_H_LSB:
                begin
                    crc_next   = crc_new;
                    raw_h_next = {raw_h_reg[15:8], rx_byte};
                    pos_next   = hsfd_pkg::POS_H_CRC;
                end
                default:
                begin
                    crc_next = hsfd_pkg::CRC_INIT;
                    pos_next = hsfd_pkg::POS_T_MSB;
                end
            endcase
        end
    end

    // job for the back end; temperature check wins over humidity
    always_comb
    begin
        push             = take && is_last;
        push_data.raw_t  = raw_t_reg;
        push_data.raw_h  = raw_h_reg;
        if (tbad_reg)
            push_data.status = hsfd_pkg::ST_TEMP_BAD;
        else if (hum_bad)
            push_data.status = hsfd_pkg::ST_HUM_BAD;
        else
            push_data.status = hsfd_pkg::ST_OK;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= hsfd_pkg::POS_T_MSB;
            crc_reg  <= hsfd_pkg::CRC_INIT;
            tbad_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            tbad_reg <= tbad_next;
        end
    end

    // raw words, no reset needed
    always_ff @(posedge clk)
    begin
        raw_t_reg <= raw_t_next;
        raw_h_reg <= raw_h_next;
    end

endmodule
`default_nettype wire

// ===== design/hsfd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_queue: short job queue between front and back
// Register-array FIFO; head entry is presented whenever the queue holds one.
// ----------------------------------------------------------------------------
module hsfd_queue #(
    parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hsfd_pkg::job_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output hsfd_pkg::job_t       pop_data,
    output logic                 not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsfd_pkg::job_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

`ifndef NO_ASSERTIONS
    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("hsfd_queue: push while full");

    // occupancy bounded by depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("hsfd_queue: count beyond depth");

    // a lone push raises the count by one on the next edge
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("hsfd_queue: count did not follow push");
`endif

endmodule
`default_nettype wire

// ===== design/hsfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_back: conversion pipeline for the sensor reply decoder
// Stage 1 scales the raw words, stage 2 divides by 65535 with one
// correction step and fills the output register.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output logic                     job_ready,
    input  wire hsfd_pkg::job_t      job,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [8:0]        temperature_c,
    output logic [6:0]               humidity_pct,
    output logic [1:0]               status
);

    localparam logic [16:0] FULL17 = 17'(hsfd_pkg::RAW_FULL);

    // stage 1
    logic        s1_valid_reg;
    logic [23:0] prod_t_reg, prod_t_next;
    logic [22:0] prod_h_reg, prod_h_next;
    logic [1:0]  s1_status_reg;

    // stage 2 / output
    logic              out_valid_reg;
    logic signed [8:0] temp_reg, temp_next;
    logic [6:0]        hum_reg, hum_next;
    logic [1:0]        status_reg;

    logic        s2_load;
    logic [7:0]  q0_t;
    logic [16:0] rem_t;
    logic        ge_t;
    logic [7:0]  a_t;
    logic        frac_t;
    logic        adj_t;
    logic [6:0]  q0_h;
    logic [16:0] rem_h;
    logic        ge_h;

    // pipeline flow
    assign s2_load   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !s1_valid_reg || s2_load;

    // raw * scale
    assign prod_t_next = {8'd0, job.raw_t} * 24'(hsfd_pkg::TEMP_SCALE);
    assign prod_h_next = {7'd0, job.raw_h} * 23'(hsfd_pkg::HUM_SCALE);

    // x / 65535: estimate x >> 16, remainder (x & 0xFFFF) + estimate, fix once
    assign q0_t   = prod_t_reg[23:16];
    assign rem_t  = {1'b0, prod_t_reg[15:0]} + {9'd0, q0_t};
    assign ge_t   = (rem_t >= FULL17);
    assign a_t    = q0_t + {7'd0, ge_t};
    assign frac_t = (rem_t != '0) && (rem_t != FULL17);
    // below the offset the quotient truncates toward zero
    assign adj_t  = (a_t < 8'(hsfd_pkg::TEMP_OFFSET)) && frac_t;

    assign q0_h   = prod_h_reg[22:16];
    assign rem_h  = {1'b0, prod_h_reg[15:0]} + {10'd0, q0_h};
    assign ge_h   = (rem_h >= FULL17);

    // error results carry zero values
    always_comb
    begin
        if (s1_status_reg == hsfd_pkg::ST_OK)
        begin
            temp_next = $signed({1'b0, a_t} - 9'(hsfd_pkg::TEMP_OFFSET) + {8'd0, adj_t});
            hum_next  = q0_h + {6'd0, ge_h};
        end
        else
        begin
            temp_next = '0;
            hum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
                s1_valid_reg <= job_valid;
            if (s2_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            prod_t_reg    <= prod_t_next;
            prod_h_reg    <= prod_h_next;
            s1_status_reg <= job.status;
        end
        if (s2_load)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= s1_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign temperature_c = temp_reg;
    assign humidity_pct  = hum_reg;
    assign status        = status_reg;

`ifndef NO_ASSERTIONS
    // a failed check reports zero values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != hsfd_pkg::ST_OK) |-> (temperature_c == 0 && humidity_pct == 0))
        else $error("hsfd_back: nonzero values on error");

    // converted values stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (humidity_pct <= 7'd100 && temperature_c >= -9'sd45
                       && temperature_c <= 9'sd130))
        else $error("hsfd_back: value out of range");

    // a held result blocks stage 1 from moving
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !s2_load)
        else $error("hsfd_back: overwrote a held result");
`endif

endmodule
`default_nettype wire

// ===== design/humidity_sensor_frame_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decode: six-byte temperature/humidity reply decoder
// Throughput: one request per cycle; no byte is refused unless the job queue is full.
// Result path: once the sixth byte is taken, its job is registered in the queue, then the scale stage, then the divide.
// Reset: asynchronous, clears position, CRC and valid state; raw words are not reset.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decode #(
    parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic signed [8:0]  temperature_c,
    output logic [6:0]         humidity_pct,
    output logic [1:0]         status
);

    logic           push;
    hsfd_pkg::job_t push_data;
    logic           q_full;
    logic           q_pop;
    hsfd_pkg::job_t q_data;
    logic           q_not_empty;

    // byte intake and CRC
    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    // job queue
    hsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty)
    );

    // conversion and output register
    hsfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_not_empty),
        .job_ready     (q_pop),
        .job           (q_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .temperature_c (temperature_c),
        .humidity_pct  (humidity_pct),
        .status        (status)
    );

endmodule
`default_nettype wire
